### hdl/pewb_pkg.sv
// ---------------------------------------------------------------------------
// pewb_pkg: shared types and constants for the particle integrator
// Command and status structures, configuration layout, register map and
// state encoding used by the controller, datapath and top level.
// ---------------------------------------------------------------------------
package pewb_pkg;

  localparam int FIX_W     = 32;
  localparam int TS_BITS   = 16;
  localparam int REST_DIV  = 20000;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int MASS_W    = 16;
  localparam int RADIUS_W  = 12;
  localparam int AREA_W    = 13;

  localparam logic [1:0] OP_FORCE   = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_PLACE   = 2'd2;

  localparam logic [1:0] REG_MASS        = 2'd0;
  localparam logic [1:0] REG_RADIUS      = 2'd1;
  localparam logic [1:0] REG_AREA_WIDTH  = 2'd2;
  localparam logic [1:0] REG_AREA_HEIGHT = 2'd3;

  localparam logic [MASS_W-1:0]   MASS_RESET        = 16'd1;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET      = 12'd10;
  localparam logic [AREA_W-1:0]   AREA_WIDTH_RESET  = 13'd800;
  localparam logic [AREA_W-1:0]   AREA_HEIGHT_RESET = 13'd600;

  typedef logic signed [FIX_W-1:0] fix_t;

  typedef struct packed {
    logic [MASS_W-1:0]   mass;
    logic [RADIUS_W-1:0] radius;
    logic [AREA_W-1:0]   area_width;
    logic [AREA_W-1:0]   area_height;
  } cfg_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_PLACE,
    DP_DIV_X,
    DP_DIV_Y,
    DP_VEL_X,
    DP_VEL_Y,
    DP_MUL_FX,
    DP_MUL_FY,
    DP_MUL_VX,
    DP_MUL_VY,
    DP_MUL_SQX,
    DP_MUL_SQY,
    DP_MOM_X,
    DP_MOM_Y,
    DP_POS_X,
    DP_POS_Y,
    DP_SQ_HOLD,
    DP_REST,
    DP_WALL_R,
    DP_WALL_L,
    DP_WALL_B,
    DP_WALL_T,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       out_busy;
    logic [1:0] opcode;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_F_MULX,
    S_F_MOMX,
    S_F_MULY,
    S_F_MOMY,
    S_A_DIVX,
    S_A_WAITX,
    S_A_DIVY,
    S_A_WAITY,
    S_A_MULX,
    S_A_POSX,
    S_A_MULY,
    S_A_POSY,
    S_A_SQX,
    S_A_SQHOLD,
    S_A_SQY,
    S_A_REST,
    S_A_WALLR,
    S_A_WALLL,
    S_A_WALLB,
    S_A_WALLT,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

### hdl/pewb_in_if.sv
// ---------------------------------------------------------------------------
// pewb_in_if: input channel of the particle integrator
// Valid/ready channel carrying one opcode with its force, step and place data.
// ---------------------------------------------------------------------------
interface pewb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic [15:0]        time_step;
  logic signed [31:0] place_x;
  logic signed [31:0] place_y;

  modport source (
    output valid, opcode, force_x, force_y, time_step, place_x, place_y,
    input  ready
  );

  modport sink (
    input  valid, opcode, force_x, force_y, time_step, place_x, place_y,
    output ready
  );
endinterface

### hdl/pewb_out_if.sv
// ---------------------------------------------------------------------------
// pewb_out_if: result channel of the particle integrator
// Valid/ready channel carrying the particle state after one transaction.
// ---------------------------------------------------------------------------
interface pewb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] momentum_out_x;
  logic signed [31:0] momentum_out_y;
  logic signed [31:0] velocity_out_x;
  logic signed [31:0] velocity_out_y;
  logic [3:0]         wall_hits;
  logic               at_rest;
  logic               saturated;

  modport source (
    output valid, position_x, position_y, momentum_out_x, momentum_out_y,
           velocity_out_x, velocity_out_y, wall_hits, at_rest, saturated,
    input  ready
  );

  modport sink (
    input  valid, position_x, position_y, momentum_out_x, momentum_out_y,
           velocity_out_x, velocity_out_y, wall_hits, at_rest, saturated,
    output ready
  );
endinterface

### hdl/pewb_div.sv
// ---------------------------------------------------------------------------
// pewb_div: iterative unsigned divider
// Restoring division of a 32-bit magnitude by a 16-bit divisor, two quotient
// bits per cycle; done pulses when the quotient is ready.
// ---------------------------------------------------------------------------
module pewb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pewb_pkg::FIX_W-1:0]  dividend,
  input  logic [pewb_pkg::MASS_W-1:0] divisor,
  output logic                        done,
  output logic [pewb_pkg::FIX_W-1:0]  quot
);
  import pewb_pkg::*;

  localparam int DIV_CYCLES = FIX_W / 2;
  localparam int CNT_W      = $clog2(DIV_CYCLES);

  logic [FIX_W-1:0]  q;
  logic [MASS_W-1:0] rem;
  logic [MASS_W-1:0] d;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [MASS_W:0]   s1;
  logic [MASS_W:0]   s2;

  function automatic logic [MASS_W:0] div_step(input logic [MASS_W-1:0] r,
                                               input logic b,
                                               input logic [MASS_W-1:0] dv);
    logic [MASS_W:0] t;
    logic [MASS_W:0] diff;
    t    = {r, b};
    diff = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      return {1'b1, diff[MASS_W-1:0]};
    end
    return {1'b0, t[MASS_W-1:0]};
  endfunction

  assign s1   = div_step(rem, q[FIX_W-1], d);
  assign s2   = div_step(s1[MASS_W-1:0], q[FIX_W-2], d);
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        rem  <= '0;
        d    <= divisor;
      end else if (busy) begin
        q   <= {q[FIX_W-3:0], s1[MASS_W], s2[MASS_W]};
        rem <= s2[MASS_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_busy_ends_in_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |=> (busy || done))
    else $error("divider dropped out of busy without done");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

endmodule

### hdl/pewb_dp.sv
// ---------------------------------------------------------------------------
// pewb_dp: datapath of the particle integrator
// Particle state, shared multiplier, divider, saturating adders, wall clamp
// and the result register; every step is selected by the controller command.
// ---------------------------------------------------------------------------
module pewb_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pewb_pkg::cfg_t            cfg,
  input  pewb_pkg::cmd_t            cmd,
  output pewb_pkg::stat_t           stat,
  input  logic [1:0]                in_opcode,
  input  logic signed [31:0]        in_force_x,
  input  logic signed [31:0]        in_force_y,
  input  logic [15:0]               in_time_step,
  input  logic signed [31:0]        in_place_x,
  input  logic signed [31:0]        in_place_y,
  pewb_out_if.source                out_ch
);
  import pewb_pkg::*;

  localparam int RW = (FRAC_BITS + 15 > 34) ? FRAC_BITS + 15 : 34;
  localparam logic [63:0] REST_THR =
    ((64'd1 << (2 * FRAC_BITS)) + 64'(REST_DIV) - 64'd1) / 64'(REST_DIV);
  localparam fix_t FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

  logic [1:0]        op_q;
  fix_t              fx, fy, px, py;
  logic [15:0]       dt;
  fix_t              pos_x, pos_y, mom_x, mom_y, vel_x, vel_y;
  fix_t              pos_x_next, pos_y_next, mom_x_next, mom_y_next;
  fix_t              vel_x_next, vel_y_next;
  logic [3:0]        hits, hits_next;
  logic              rest, rest_next;
  logic              sat, sat_next;
  logic signed [65:0] prod;
  logic signed [32:0] mul_a, mul_b;
  logic              mul_en;
  logic [63:0]       sq_sum;
  logic [63:0]       sq_total;
  logic              div_neg;
  logic              div_start;
  logic [FIX_W-1:0]  div_dividend;
  logic [MASS_W-1:0] div_divisor;
  logic              div_done;
  logic [FIX_W-1:0]  div_quot;
  fix_t              scaled;
  fix_t              quot_signed;
  logic signed [RW-1:0] rfix, wfix, hfix, pxe, pye;
  logic signed [RW-1:0] x_plus_r, x_minus_r, y_plus_r, y_minus_r;
  logic signed [RW-1:0] w_minus_r, h_minus_r;

  function automatic logic [FIX_W-1:0] abs_fix(input fix_t v);
    return v[FIX_W-1] ? FIX_W'(-v) : v;
  endfunction

  function automatic logic [FIX_W:0] add_sat(input fix_t a, input fix_t b);
    logic signed [FIX_W:0] s;
    logic ovf;
    s   = {a[FIX_W-1], a} + {b[FIX_W-1], b};
    ovf = s[FIX_W] ^ s[FIX_W-1];
    if (ovf) begin
      return {1'b1, (s[FIX_W] ? FIX_MIN : FIX_MAX)};
    end
    return {1'b0, s[FIX_W-1:0]};
  endfunction

  function automatic logic [FIX_W:0] neg_sat(input fix_t v);
    if (v == FIX_MIN) begin
      return {1'b1, FIX_MAX};
    end
    return {1'b0, FIX_W'(-v)};
  endfunction

  function automatic logic [FIX_W:0] clamp_w(input logic signed [RW-1:0] v);
    logic ovf;
    ovf = !((&v[RW-1:FIX_W-1]) || (~|v[RW-1:FIX_W-1]));
    if (ovf) begin
      return {1'b1, (v[RW-1] ? FIX_MIN : FIX_MAX)};
    end
    return {1'b0, v[FIX_W-1:0]};
  endfunction

  assign rfix = {{(RW-RADIUS_W-FRAC_BITS){1'b0}}, cfg.radius, {FRAC_BITS{1'b0}}};
  assign wfix = {{(RW-AREA_W-FRAC_BITS){1'b0}}, cfg.area_width, {FRAC_BITS{1'b0}}};
  assign hfix = {{(RW-AREA_W-FRAC_BITS){1'b0}}, cfg.area_height, {FRAC_BITS{1'b0}}};
  assign pxe  = {{(RW-FIX_W){pos_x[FIX_W-1]}}, pos_x};
  assign pye  = {{(RW-FIX_W){pos_y[FIX_W-1]}}, pos_y};

  assign x_plus_r  = pxe + rfix;
  assign x_minus_r = pxe - rfix;
  assign y_plus_r  = pye + rfix;
  assign y_minus_r = pye - rfix;
  assign w_minus_r = wfix - rfix;
  assign h_minus_r = hfix - rfix;

  assign scaled      = prod[TS_BITS+FIX_W-1:TS_BITS];
  assign sq_total    = sq_sum + prod[63:0];
  assign quot_signed = div_neg ? FIX_W'(-$signed(div_quot)) : $signed(div_quot);

  assign div_start    = (cmd.op == DP_DIV_X) || (cmd.op == DP_DIV_Y);
  assign div_dividend = (cmd.op == DP_DIV_Y) ? abs_fix(mom_y) : abs_fix(mom_x);
  assign div_divisor  = (cfg.mass == '0) ? MASS_W'(1) : cfg.mass;

  pewb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      DP_MUL_FX: begin
        mul_a = {fx[FIX_W-1], fx};
        mul_b = {17'b0, dt};
      end
      DP_MUL_FY: begin
        mul_a = {fy[FIX_W-1], fy};
        mul_b = {17'b0, dt};
      end
      DP_MUL_VX: begin
        mul_a = {vel_x[FIX_W-1], vel_x};
        mul_b = {17'b0, dt};
      end
      DP_MUL_VY: begin
        mul_a = {vel_y[FIX_W-1], vel_y};
        mul_b = {17'b0, dt};
      end
      DP_MUL_SQX: begin
        mul_a = {1'b0, abs_fix(vel_x)};
        mul_b = {1'b0, abs_fix(vel_x)};
      end
      DP_MUL_SQY: begin
        mul_a = {1'b0, abs_fix(vel_y)};
        mul_b = {1'b0, abs_fix(vel_y)};
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    logic [FIX_W:0] t;
    logic [FIX_W:0] u;
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    mom_x_next = mom_x;
    mom_y_next = mom_y;
    vel_x_next = vel_x;
    vel_y_next = vel_y;
    hits_next  = hits;
    rest_next  = rest;
    sat_next   = sat;
    t = '0;
    u = '0;
    case (cmd.op)
      DP_CAPTURE: begin
        hits_next = '0;
        rest_next = 1'b0;
        sat_next  = 1'b0;
      end
      DP_PLACE: begin
        pos_x_next = px;
        pos_y_next = py;
        mom_x_next = '0;
        mom_y_next = '0;
      end
      DP_VEL_X: vel_x_next = quot_signed;
      DP_VEL_Y: vel_y_next = quot_signed;
      DP_MOM_X: begin
        t = add_sat(mom_x, scaled);
        mom_x_next = t[FIX_W-1:0];
        sat_next   = sat | t[FIX_W];
      end
      DP_MOM_Y: begin
        t = add_sat(mom_y, scaled);
        mom_y_next = t[FIX_W-1:0];
        sat_next   = sat | t[FIX_W];
      end
      DP_POS_X: begin
        t = add_sat(pos_x, scaled);
        pos_x_next = t[FIX_W-1:0];
        sat_next   = sat | t[FIX_W];
      end
      DP_POS_Y: begin
        t = add_sat(pos_y, scaled);
        pos_y_next = t[FIX_W-1:0];
        sat_next   = sat | t[FIX_W];
      end
      DP_REST: begin
        if (sq_total < REST_THR) begin
          mom_x_next = '0;
          mom_y_next = '0;
          rest_next  = 1'b1;
        end
      end
      DP_WALL_R: begin
        if (x_plus_r > wfix) begin
          t = clamp_w(w_minus_r);
          u = neg_sat(mom_x);
          pos_x_next   = t[FIX_W-1:0];
          mom_x_next   = u[FIX_W-1:0];
          sat_next     = sat | t[FIX_W] | u[FIX_W];
          hits_next[0] = 1'b1;
        end
      end
      DP_WALL_L: begin
        if (x_minus_r < 0) begin
          t = clamp_w(rfix);
          u = neg_sat(mom_x);
          pos_x_next   = t[FIX_W-1:0];
          mom_x_next   = u[FIX_W-1:0];
          sat_next     = sat | t[FIX_W] | u[FIX_W];
          hits_next[1] = 1'b1;
        end
      end
      DP_WALL_B: begin
        if (y_plus_r > hfix) begin
          t = clamp_w(h_minus_r);
          u = neg_sat(mom_y);
          pos_y_next   = t[FIX_W-1:0];
          mom_y_next   = u[FIX_W-1:0];
          sat_next     = sat | t[FIX_W] | u[FIX_W];
          hits_next[2] = 1'b1;
        end
      end
      DP_WALL_T: begin
        if (y_minus_r < 0) begin
          t = clamp_w(rfix);
          u = neg_sat(mom_y);
          pos_y_next   = t[FIX_W-1:0];
          mom_y_next   = u[FIX_W-1:0];
          sat_next     = sat | t[FIX_W] | u[FIX_W];
          hits_next[3] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      mom_x <= '0;
      mom_y <= '0;
      vel_x <= '0;
      vel_y <= '0;
      hits  <= '0;
      rest  <= 1'b0;
      sat   <= 1'b0;
    end else begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      mom_x <= mom_x_next;
      mom_y <= mom_y_next;
      vel_x <= vel_x_next;
      vel_y <= vel_y_next;
      hits  <= hits_next;
      rest  <= rest_next;
      sat   <= sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      op_q <= in_opcode;
      fx   <= in_force_x;
      fy   <= in_force_y;
      dt   <= in_time_step;
      px   <= in_place_x;
      py   <= in_place_y;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.op == DP_SQ_HOLD) begin
      sq_sum <= prod[63:0];
    end
    if (cmd.op == DP_DIV_X) begin
      div_neg <= mom_x[FIX_W-1];
    end else if (cmd.op == DP_DIV_Y) begin
      div_neg <= mom_y[FIX_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.op == DP_PUBLISH) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_PUBLISH) begin
      out_ch.position_x     <= pos_x;
      out_ch.position_y     <= pos_y;
      out_ch.momentum_out_x <= mom_x;
      out_ch.momentum_out_y <= mom_y;
      out_ch.velocity_out_x <= vel_x;
      out_ch.velocity_out_y <= vel_y;
      out_ch.wall_hits      <= hits;
      out_ch.at_rest        <= rest;
      out_ch.saturated      <= sat;
    end
  end

  assign stat.div_done = div_done;
  assign stat.out_busy = out_ch.valid && !out_ch.ready;
  assign stat.opcode   = op_q;

  a_rest_zero_momentum: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.at_rest) |->
      (out_ch.momentum_out_x == '0 && out_ch.momentum_out_y == '0))
    else $error("at_rest published with nonzero momentum");

  a_flags_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_PUBLISH && op_q != OP_ADVANCE) |=>
      (out_ch.wall_hits == '0 && !out_ch.at_rest))
    else $error("wall or rest flag on a non-advance transaction");

endmodule

### hdl/pewb_ctrl.sv
// ---------------------------------------------------------------------------
// pewb_ctrl: controller of the particle integrator
// Sequences capture, force, advance and place steps, waits on the divider
// and hands the finished state to the result register.
// ---------------------------------------------------------------------------
module pewb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pewb_pkg::stat_t stat,
  output pewb_pkg::cmd_t  cmd
);
  import pewb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (stat.opcode)
          OP_FORCE:   state_next = S_F_MULX;
          OP_ADVANCE: state_next = S_A_DIVX;
          OP_PLACE:   state_next = S_PLACE;
          default:    state_next = S_DONE;
        endcase
      end
      S_F_MULX:   state_next = S_F_MOMX;
      S_F_MOMX:   state_next = S_F_MULY;
      S_F_MULY:   state_next = S_F_MOMY;
      S_F_MOMY:   state_next = S_DONE;
      S_A_DIVX:   state_next = S_A_WAITX;
      S_A_WAITX:  if (stat.div_done) state_next = S_A_DIVY;
      S_A_DIVY:   state_next = S_A_WAITY;
      S_A_WAITY:  if (stat.div_done) state_next = S_A_MULX;
      S_A_MULX:   state_next = S_A_POSX;
      S_A_POSX:   state_next = S_A_MULY;
      S_A_MULY:   state_next = S_A_POSY;
      S_A_POSY:   state_next = S_A_SQX;
      S_A_SQX:    state_next = S_A_SQHOLD;
      S_A_SQHOLD: state_next = S_A_SQY;
      S_A_SQY:    state_next = S_A_REST;
      S_A_REST:   state_next = S_A_WALLR;
      S_A_WALLR:  state_next = S_A_WALLL;
      S_A_WALLL:  state_next = S_A_WALLB;
      S_A_WALLB:  state_next = S_A_WALLT;
      S_A_WALLT:  state_next = S_DONE;
      S_PLACE:    state_next = S_DONE;
      S_DONE:     if (!stat.out_busy) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = DP_NOP;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_CAPTURE;
      end
      S_DISPATCH: cmd.op = DP_NOP;
      S_F_MULX:   cmd.op = DP_MUL_FX;
      S_F_MOMX:   cmd.op = DP_MOM_X;
      S_F_MULY:   cmd.op = DP_MUL_FY;
      S_F_MOMY:   cmd.op = DP_MOM_Y;
      S_A_DIVX:   cmd.op = DP_DIV_X;
      S_A_WAITX:  if (stat.div_done) cmd.op = DP_VEL_X;
      S_A_DIVY:   cmd.op = DP_DIV_Y;
      S_A_WAITY:  if (stat.div_done) cmd.op = DP_VEL_Y;
      S_A_MULX:   cmd.op = DP_MUL_VX;
      S_A_POSX:   cmd.op = DP_POS_X;
      S_A_MULY:   cmd.op = DP_MUL_VY;
      S_A_POSY:   cmd.op = DP_POS_Y;
      S_A_SQX:    cmd.op = DP_MUL_SQX;
      S_A_SQHOLD: cmd.op = DP_SQ_HOLD;
      S_A_SQY:    cmd.op = DP_MUL_SQY;
      S_A_REST:   cmd.op = DP_REST;
      S_A_WALLR:  cmd.op = DP_WALL_R;
      S_A_WALLL:  cmd.op = DP_WALL_L;
      S_A_WALLB:  cmd.op = DP_WALL_B;
      S_A_WALLT:  cmd.op = DP_WALL_T;
      S_PLACE:    cmd.op = DP_PLACE;
      S_DONE:     if (!stat.out_busy) cmd.op = DP_PUBLISH;
      default:    cmd.op = DP_NOP;
    endcase
  end

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_A_WAITX || state == S_A_WAITY))
    else $error("divider finished outside a wait state");

endmodule

### hdl/particle_euler_wall_bounce_top.sv
// ---------------------------------------------------------------------------
// particle_euler_wall_bounce_top: fixed-point particle integrator in a box
// One transaction at a time; an advance waits on the two radix-4 momentum
// divides, and the next input is accepted in the idle state that follows
// the registering of the result.
// Reset clears the particle state and loads the register defaults.
// ---------------------------------------------------------------------------
module particle_euler_wall_bounce_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  pewb_in_if.sink                      in_ch,
  pewb_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pewb_pkg::PADDR_W-1:0] paddr,
  input  logic [pewb_pkg::PDATA_W-1:0] pwdata,
  output logic [pewb_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import pewb_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  stat_t      stat;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mass        <= MASS_RESET;
      cfg.radius      <= RADIUS_RESET;
      cfg.area_width  <= AREA_WIDTH_RESET;
      cfg.area_height <= AREA_HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        REG_MASS:        cfg.mass        <= pwdata[MASS_W-1:0];
        REG_RADIUS:      cfg.radius      <= pwdata[RADIUS_W-1:0];
        REG_AREA_WIDTH:  cfg.area_width  <= pwdata[AREA_W-1:0];
        REG_AREA_HEIGHT: cfg.area_height <= pwdata[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      REG_MASS:        prdata = PDATA_W'(cfg.mass);
      REG_RADIUS:      prdata = PDATA_W'(cfg.radius);
      REG_AREA_WIDTH:  prdata = PDATA_W'(cfg.area_width);
      REG_AREA_HEIGHT: prdata = PDATA_W'(cfg.area_height);
      default:         prdata = '0;
    endcase
  end

  pewb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pewb_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .in_opcode    (in_ch.opcode),
    .in_force_x   (in_ch.force_x),
    .in_force_y   (in_ch.force_y),
    .in_time_step (in_ch.time_step),
    .in_place_x   (in_ch.place_x),
    .in_place_y   (in_ch.place_y),
    .out_ch       (out_ch)
  );

endmodule
